/* rtl/aes128_cbc_encrypt_assert.svh */
// Assertion macros used by the checker file of the AES-128 CBC encryptor.
`ifndef AES128_CBC_ENCRYPT_ASSERT_SVH
`define AES128_CBC_ENCRYPT_ASSERT_SVH

// Asserts that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Asserts that an antecedent implies a consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/aes_pkg.sv */
// Package with AES-128 constants, types and round functions.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HIGH   = 3'd0,
    CFG_KEY_LOW    = 3'd1,
    CFG_IV_HIGH    = 3'd2,
    CFG_IV_LOW     = 3'd3,
    CFG_CHAIN_MODE = 3'd4
  } cfg_idx_e;

  typedef logic [63:0]  word64_t;
  typedef logic [127:0] block_t;
  typedef logic [31:0]  column_t;
  typedef logic [3:0]   round_t;

  // Control sent from the top level to the round datapath.
  typedef struct packed {
    logic   load;
    logic   step;
    logic   last;
  } round_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant for the key schedule step that makes round key r (1..10).
  function automatic logic [7:0] rcon(input round_t r);
    logic [7:0] v;
    v = 8'h00;
    unique case (r)
      4'd1:  v = 8'h01;
      4'd2:  v = 8'h02;
      4'd3:  v = 8'h04;
      4'd4:  v = 8'h08;
      4'd5:  v = 8'h10;
      4'd6:  v = 8'h20;
      4'd7:  v = 8'h40;
      4'd8:  v = 8'h80;
      4'd9:  v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Multiplication by two in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

/* rtl/aes_stream_if.sv */
// Valid/ready stream interface that carries one payload type.
interface aes_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/aes_key_sched.sv */
// Key schedule: expands the cipher key one round key per cycle into a store.
module aes_key_sched
  import aes_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  block_t key_i,
  input  round_t rd_round_i,
  output block_t rd_key_o,
  output logic   busy_o
);

  block_t rk_q [NumRounds+1];
  round_t idx_q, idx_d;
  logic   busy_q, busy_d;
  block_t prev;
  block_t next_key;
  column_t rot;
  column_t w0, w1, w2, w3;

  // One expansion step from the previous round key.
  always_comb begin
    prev = rk_q[idx_q - 4'd1];
    rot  = {SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]], SBOX[prev[31:24]]};
    rot  = rot ^ {rcon(idx_q), 24'h0};
    w0   = prev[127:96] ^ rot;
    w1   = prev[95:64] ^ w0;
    w2   = prev[63:32] ^ w1;
    w3   = prev[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  end

  // Step counter over rounds one to ten.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = 4'd1;
    end else if (busy_q) begin
      if (idx_q == round_t'(NumRounds)) begin
        busy_d = 1'b0;
      end
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= 4'd1;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Round key store, key 0 is the cipher key itself.
  always_ff @(posedge clk_i) begin
    if (start_i || !rst_ni) begin
      rk_q[0] <= key_i;
    end else if (busy_q) begin
      rk_q[idx_q] <= next_key;
    end
  end

  assign rd_key_o = rk_q[rd_round_i];
  assign busy_o   = busy_q;

endmodule

/* rtl/aes_lane.sv */
// One column lane: SubBytes with ShiftRows input, optional MixColumns, AddRoundKey.
module aes_lane
  import aes_pkg::*;
(
  input  column_t col_i,
  input  logic    last_i,
  input  column_t rk_i,
  output column_t col_o
);

  logic [7:0] a0, a1, a2, a3, all;
  column_t mixed;

  always_comb begin
    a0 = SBOX[col_i[31:24]];
    a1 = SBOX[col_i[23:16]];
    a2 = SBOX[col_i[15:8]];
    a3 = SBOX[col_i[7:0]];
    all = a0 ^ a1 ^ a2 ^ a3;
    mixed = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
             a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
    col_o = (last_i ? {a0, a1, a2, a3} : mixed) ^ rk_i;
  end

endmodule

/* rtl/aes_round.sv */
// Round datapath: ShiftRows routing to four column lanes and the merged state register.
module aes_round
  import aes_pkg::*;
(
  input  logic        clk_i,
  input  round_ctrl_t ctrl_i,
  input  block_t      init_i,
  input  block_t      rk_i,
  output block_t      state_o
);

  block_t  state_q;
  column_t lane_in  [NumLanes];
  column_t lane_out [NumLanes];
  block_t  merged;

  // Lane c, row r takes the state byte at row r, column (c + r) mod 4 (byte 0 is the most significant).
  for (genvar c = 0; c < NumLanes; c++) begin : g_lane
    for (genvar r = 0; r < 4; r++) begin : g_row
      localparam int Src = 4 * ((c + r) % 4) + r;
      assign lane_in[c][31-8*r -: 8] = state_q[127-8*Src -: 8];
    end
    aes_lane u_lane (
      .col_i  (lane_in[c]),
      .last_i (ctrl_i.last),
      .rk_i   (rk_i[127-32*c -: 32]),
      .col_o  (lane_out[c])
    );
    assign merged[127-32*c -: 32] = lane_out[c];
  end

  // Initial AddRoundKey on load, one round per step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      state_q <= init_i ^ rk_i;
    end else if (ctrl_i.step) begin
      state_q <= merged;
    end
  end

  assign state_o = state_q;

endmodule

/* rtl/aes128_cbc_encrypt.sv */
// AES-128 encryptor with CBC chaining (or ECB when chaining is off), one block in flight at a time.
// Each accepted transaction passes through the states LOAD, RUN and DONE: LOAD loads the
// whitened block, then the shared four-lane round unit runs the ten rounds one per cycle,
// and DONE puts the result in an output register. The next block is accepted only once the
// result has left the output register, so blocks never overlap and a stalled sink adds
// its stall; CBC needs the previous ciphertext.
// After reset and after each key write the key schedule expands the round keys, during
// which no block is accepted. Config writes are expected only while idle.
module aes128_cbc_encrypt
  import aes_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  aes_stream_if.sink           in_if,
  aes_stream_if.source         out_if
);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_DONE} state_e;

  state_e      state_q;
  round_t      rnd_q;
  word64_t     key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        mode_q;
  block_t      chain_q;
  block_t      blk_q;
  block_t      out_q;
  logic        out_valid_q;
  logic        ks_busy, ks_start;
  block_t      rk, state;
  round_t      rd_round;
  round_ctrl_t ctrl;

  assign ks_start = cfg_we_i && (cfg_idx_i == CFG_KEY_HIGH || cfg_idx_i == CFG_KEY_LOW);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
      mode_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_HIGH:   key_hi_q <= cfg_data_i;
        CFG_KEY_LOW:    key_lo_q <= cfg_data_i;
        CFG_IV_HIGH:    iv_hi_q  <= cfg_data_i;
        CFG_IV_LOW:     iv_lo_q  <= cfg_data_i;
        CFG_CHAIN_MODE: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  aes_key_sched u_ks (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ks_start),
    .key_i      (ks_start ? (cfg_idx_i == CFG_KEY_HIGH ? {cfg_data_i, key_lo_q}
                                                        : {key_hi_q, cfg_data_i})
                          : {key_hi_q, key_lo_q}),
    .rd_round_i (rd_round),
    .rd_key_o   (rk),
    .busy_o     (ks_busy)
  );

  assign rd_round  = (state_q == ST_LOAD) ? 4'd0 : rnd_q;
  assign ctrl.load = (state_q == ST_LOAD);
  assign ctrl.step = (state_q == ST_RUN);
  assign ctrl.last = (rnd_q == round_t'(NumRounds));

  aes_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .init_i  (blk_q),
    .rk_i    (rk),
    .state_o (state)
  );

  assign in_if.ready = (state_q == ST_IDLE) && !ks_busy && !ks_start && !out_valid_q;

  // Sequencer: chaining XOR on accept (CBC mode only), ten rounds, result into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= 4'd1;
      chain_q     <= '0;
      blk_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            state_q <= ST_LOAD;
            if (!mode_q) begin
              blk_q <= {in_if.data.plain_high, in_if.data.plain_low};
            end else if (in_if.data.first_block) begin
              blk_q <= {in_if.data.plain_high ^ iv_hi_q, in_if.data.plain_low ^ iv_lo_q};
            end else begin
              blk_q <= {in_if.data.plain_high, in_if.data.plain_low} ^ chain_q;
            end
          end
        end
        ST_LOAD: begin
          state_q <= ST_RUN;
          rnd_q   <= 4'd1;
        end
        ST_RUN: begin
          if (rnd_q == round_t'(NumRounds)) begin
            state_q <= ST_DONE;
          end else begin
            rnd_q <= rnd_q + 4'd1;
          end
        end
        ST_DONE: begin
          state_q     <= ST_IDLE;
          chain_q     <= state;
          out_q       <= state;
          out_valid_q <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.data.cipher_high = out_q[127:64];
  assign out_if.data.cipher_low  = out_q[63:0];

endmodule

/* rtl/aes_checker.sv */
// Port-level checker for the AES-128 CBC encryptor and its bind.
`include "aes128_cbc_encrypt_assert.svh"
module aes_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [127:0] out_data_i
);
  // A result waiting for its sink keeps its value.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
               out_valid_i && $stable(out_data_i), "result dropped or changed while stalled")
  // Only one block in flight: no accept while a result waits.
  `ASSERT_SAME(a_one_inflight, clk_i, rst_ni, out_valid_i, !in_ready_i,
               "input accepted while result pending")
  // An accepted block is not ready again right away.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i,
               !in_ready_i && !out_valid_i, "block accepted twice")
endmodule

bind aes128_cbc_encrypt aes_checker u_aes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  ({out_if.data.cipher_high, out_if.data.cipher_low})
);

/* bench/aes128_cbc_encrypt_tb.sv */
// Self-checking testbench for the AES-128 CBC/ECB encryptor with random handshake stalls.
module aes128_cbc_encrypt_tb;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        first_block;
  } plain_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_item_t;

  // Cipher predictor and ciphertext store; compares results in order.
  class cipher_scoreboard;
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         cbc_on;
    block_t       last_cipher;
    logic [7:0]   sched [176];
    cipher_item_t pending [$];
    int unsigned  errors;

    function new();
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      cbc_on = 1'b1;
      last_cipher = '0;
      errors = 0;
      expand_schedule();
    endfunction

    function automatic logic [7:0] gf_double(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Full 176-byte key schedule from the current key registers.
    function void expand_schedule();
      logic [127:0] k;
      logic [7:0]   t [4];
      logic [7:0]   r;
      logic [7:0]   rc;
      k = {key_hi, key_lo};
      rc = 8'h01;
      for (int i = 0; i < 16; i++) sched[i] = k[127 - 8 * i -: 8];
      for (int i = 16; i < 176; i += 4) begin
        for (int j = 0; j < 4; j++) t[j] = sched[i - 4 + j];
        if ((i % 16) == 0) begin
          r = t[0];
          t[0] = SBOX[t[1]] ^ rc;
          t[1] = SBOX[t[2]];
          t[2] = SBOX[t[3]];
          t[3] = SBOX[r];
          rc = gf_double(rc);
        end
        for (int j = 0; j < 4; j++) sched[i + j] = sched[i - 16 + j] ^ t[j];
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] value);
      case (idx)
        CFG_KEY_HIGH: begin
          key_hi = value;
          expand_schedule();
        end
        CFG_KEY_LOW: begin
          key_lo = value;
          expand_schedule();
        end
        CFG_IV_HIGH:    iv_hi = value;
        CFG_IV_LOW:     iv_lo = value;
        CFG_CHAIN_MODE: cbc_on = value[0];
        default: ;
      endcase
    endfunction

    function block_t cipher(block_t pt);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      block_t     ct;
      for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ sched[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
        // SubBytes and ShiftRows together.
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4 * c + r] = SBOX[s[4 * ((c + r) % 4) + r]];
        s = t;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            s[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
            s[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
            s[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
            s[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] ^= sched[16 * rnd + i];
      end
      for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
      return ct;
    endfunction

    // An accepted plaintext transaction: chain, encrypt, remember the ciphertext.
    function void note_plain(plain_item_t item);
      block_t blk;
      blk = {item.plain_high, item.plain_low};
      if (cbc_on) blk ^= item.first_block ? {iv_hi, iv_lo} : last_cipher;
      last_cipher = cipher(blk);
      pending.push_back(last_cipher);
    endfunction

    function void check_cipher(cipher_item_t got);
      cipher_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected ciphertext %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.cipher_high !== want.cipher_high || got.cipher_low !== want.cipher_low) begin
        errors++;
        if (errors <= 10)
          $display("ciphertext mismatch: expected %h_%h, got %h_%h",
                   want.cipher_high, want.cipher_low, got.cipher_high, got.cipher_low);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  bit                no_idle;
  cipher_scoreboard  sb;

  aes_stream_if #(.payload_t(plain_item_t))  in_ch ();
  aes_stream_if #(.payload_t(cipher_item_t)) out_ch ();

  aes128_cbc_encrypt i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("aes128_cbc_encrypt_tb: FAIL");
    $finish;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_cipher(out_ch.data);
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_plain(in_ch.data);
  end

  // Receiver with random stall bursts.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
    end
  end

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [63:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, value);
  endtask

  // One plaintext transaction, possibly preceded by an idle burst.
  task automatic send_plain(logic [63:0] hi, logic [63:0] lo, logic first);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_ch.data = '{plain_high: hi, plain_low: lo, first_block: first};
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_config(int sel);
    case (sel)
      0: begin
        write_cfg(CFG_KEY_HIGH, '0); write_cfg(CFG_KEY_LOW, '0);
        write_cfg(CFG_IV_HIGH, '0); write_cfg(CFG_IV_LOW, '0);
      end
      1: begin
        write_cfg(CFG_KEY_HIGH, '1); write_cfg(CFG_KEY_LOW, '1);
        write_cfg(CFG_IV_HIGH, '1); write_cfg(CFG_IV_LOW, '1);
      end
      default: begin
        write_cfg(CFG_KEY_HIGH, rand64()); write_cfg(CFG_KEY_LOW, rand64());
        write_cfg(CFG_IV_HIGH, rand64()); write_cfg(CFG_IV_LOW, rand64());
      end
    endcase
    write_cfg(CFG_CHAIN_MODE, {63'd0, ($urandom_range(0, 3) != 0)});
  endtask

  // Main sequence: directed cases, then random phases with new settings.
  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    no_idle = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // CBC after reset without a first block chains from zero.
    send_plain('0, '0, 1'b0);
    send_plain('1, '1, 1'b0);
    wait_drained();

    // Standard test vector in ECB, then a second block, also in ECB.
    write_cfg(CFG_KEY_HIGH, 64'h0001020304050607);
    write_cfg(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    write_cfg(CFG_CHAIN_MODE, '0);
    send_plain(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    send_plain('1, '0, 1'b0);
    wait_drained();

    // ECB ciphertext feeds a following CBC block that is not marked first.
    write_cfg(CFG_CHAIN_MODE, 64'd1);
    write_cfg(CFG_IV_HIGH, '1);
    write_cfg(CFG_IV_LOW, 64'h0123456789abcdef);
    send_plain('0, '1, 1'b0);
    send_plain(64'h8000000000000001, '0, 1'b1);
    send_plain('1, '1, 1'b0);
    wait_drained();

    // Key change keeps the chain; out-of-range indexes are ignored.
    write_cfg(CFG_KEY_HIGH, '1);
    write_cfg(CFG_KEY_LOW, '1);
    for (int idx = 5; idx < 8; idx++) begin
      cfg_we_i = 1'b1;
      cfg_idx_i = idx[CfgIdxW-1:0];
      cfg_data_i = '1;
      @(negedge clk_i);
      cfg_we_i = 1'b0;
    end
    send_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
    send_plain('0, '0, 1'b1);
    send_plain('0, '0, 1'b0);
    wait_drained();

    // Random phases; the last one runs without stalls.
    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph);
      if (ph == 7) no_idle = 1'b1;
      for (int n = 0; n < 205; n++)
        send_plain(rand64(), rand64(), $urandom_range(0, 7) == 0);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("aes128_cbc_encrypt_tb: PASS");
    end else begin
      $display("aes128_cbc_encrypt_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_stream_if.sv
rtl/aes_key_sched.sv
rtl/aes_lane.sv
rtl/aes_round.sv
rtl/aes128_cbc_encrypt.sv
rtl/aes_checker.sv
bench/aes128_cbc_encrypt_tb.sv
